>>> design/btpg_pkg.sv
`timescale 1ns / 1ps

package btpg_pkg;

  localparam int GLYPH_COUNT = 96;
  localparam int MAX_SCALE   = 10;
  localparam int FONT_DEPTH  = GLYPH_COUNT * 8;
  localparam int FONT_AW     = $clog2(FONT_DEPTH);
  localparam int SEQ_LEN     = 11;
  localparam int SEQ_W       = $clog2(SEQ_LEN);

  localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [7:0] CHAR_FIRST     = 8'd32;
  localparam logic [7:0] CHAR_LAST      = 8'd127;
  localparam logic [7:0] CMD_COL_ADDR   = 8'h2A;
  localparam logic [7:0] CMD_ROW_ADDR   = 8'h2B;
  localparam logic [7:0] CMD_MEM_WRITE  = 8'h2C;

  localparam logic [23:0] FG_RESET    = 24'hFFFFFF;
  localparam logic [23:0] BG_RESET    = 24'h000000;
  localparam logic [3:0]  SCALE_RESET = 4'd1;

  typedef enum logic [1:0] {
    FUNC_LOAD_ROW = 2'd0,
    FUNC_SET_CURSOR = 2'd1,
    FUNC_PUT_CHAR = 2'd2,
    FUNC_NEXT_PIXEL = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_CMD   = 2'd0,
    KIND_PARAM = 2'd1,
    KIND_PIXEL = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_FG_COLOUR  = 2'd0,
    REG_BG_COLOUR  = 2'd1,
    REG_TEXT_SCALE = 2'd2,
    REG_NONE       = 2'd3
  } reg_e;

  typedef struct packed {
    func_e       func;
    logic [7:0]  char_code;
    logic [2:0]  row_index;
    logic [7:0]  row_bits;
    logic [15:0] start_x;
    logic [15:0] start_y;
  } pix_in_t;

  typedef struct packed {
    kind_e       out_kind;
    logic [15:0] out_value;
    logic        last;
  } pix_out_t;

  // Entry held in the request stage, waiting for the output register
  typedef struct packed {
    kind_e       kind;
    logic [15:0] value;
    logic        last;
    logic [2:0]  col;
  } slot_t;

  function automatic logic [15:0] to_565(input logic [23:0] c);
    return {c[23:19], c[15:10], c[7:3]};
  endfunction

  function automatic logic [3:0] eff_scale(input logic [3:0] s);
    logic [3:0] r;
    r = s;
    if (r == 4'd0) r = 4'd1;
    if (r > 4'(MAX_SCALE)) r = 4'(MAX_SCALE);
    return r;
  endfunction

  // Window setup sequence: column command, four bytes, row command, four bytes, write command
  function automatic slot_t seq_entry(input logic [SEQ_W-1:0] idx,
                                      input logic [15:0] x0, input logic [15:0] x1,
                                      input logic [15:0] y0, input logic [15:0] y1);
    slot_t e;
    e.kind  = KIND_PARAM;
    e.value = 16'd0;
    e.last  = 1'b0;
    e.col   = 3'd0;
    case (idx)
      SEQ_W'(0): begin e.kind = KIND_CMD; e.value = {8'd0, CMD_COL_ADDR}; end
      SEQ_W'(1): e.value = {8'd0, x0[15:8]};
      SEQ_W'(2): e.value = {8'd0, x0[7:0]};
      SEQ_W'(3): e.value = {8'd0, x1[15:8]};
      SEQ_W'(4): e.value = {8'd0, x1[7:0]};
      SEQ_W'(5): begin e.kind = KIND_CMD; e.value = {8'd0, CMD_ROW_ADDR}; end
      SEQ_W'(6): e.value = {8'd0, y0[15:8]};
      SEQ_W'(7): e.value = {8'd0, y0[7:0]};
      SEQ_W'(8): e.value = {8'd0, y1[15:8]};
      SEQ_W'(9): e.value = {8'd0, y1[7:0]};
      default: begin e.kind = KIND_CMD; e.value = {8'd0, CMD_MEM_WRITE}; end
    endcase
    return e;
  endfunction

endpackage

>>> design/bitmap_text_pixel_generator.sv
`timescale 1ns / 1ps

// Bitmap text pixel generator: 8x8 glyph engine with a loadable font memory.
// Input channel (in_valid_i / in_stall_o) carries one command per transaction:
// load a font row, set the cursor, put a character, or request the next pixel.
// Output channel (out_valid_o / out_stall_i) carries display command bytes,
// parameter bytes and RGB565 pixel words; last marks the final glyph pixel.
// Configuration (cfg_we_i, cfg_index_i, cfg_wdata_i) sets the two colours and
// the scale; write it only while the block is idle.
// Pixel requests are taken one per cycle while in_stall_o is low; each pixel
// passes the font read and request stage, then the output register.
// A printable character produces eleven window-setup transactions; the
// sequencer that steps through them holds off new input until all eleven
// have entered the request stage. Newline, unprintable codes, font loads
// and cursor sets produce nothing.
// Reset clears cursor, drawing state and pipeline valid bits and restores the
// colour and scale registers; font memory contents are undefined until loaded.
// When the receiver stalls, the output register holds its transaction and one
// more entry waits in the request stage; after that, input is stalled.

module bitmap_text_pixel_generator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  btpg_pkg::pix_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output btpg_pkg::pix_out_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [23:0]        cfg_wdata_i
);
  import btpg_pkg::*;

  logic [23:0] fg_q, bg_q;
  logic [3:0]  scale_q;

  logic [15:0] cursor_x_q, cursor_x_d;
  logic [15:0] cursor_y_q, cursor_y_d;
  logic [15:0] line_x_q, line_x_d;
  logic        drawing_q, drawing_d;
  logic [6:0]  glyph_q, glyph_d;
  logic [2:0]  src_row_q, src_row_d;
  logic [3:0]  row_rep_q, row_rep_d;
  logic [2:0]  src_col_q, src_col_d;
  logic [3:0]  col_rep_q, col_rep_d;

  logic [15:0] win_x0_q, win_x1_q, win_y0_q, win_y1_q;
  logic             seq_active_q, seq_active_d;
  logic [SEQ_W-1:0] seq_idx_q, seq_idx_d;

  logic [7:0]  font_mem [FONT_DEPTH];
  logic [7:0]  font_rdata_q;

  logic        s1_valid_q, s1_valid_d;
  slot_t       s1_q, s1_d;
  logic        out_valid_q, out_valid_d;
  pix_out_t    out_q, out_d;

  logic        out_free, s1_free, in_accept;
  logic        seq_emit, pix_emit, put_glyph;
  logic [3:0]  s;
  logic [15:0] step;
  logic [7:0]  code_off;
  logic        code_ok;
  logic        font_we, font_re;
  logic [FONT_AW-1:0] font_waddr, font_raddr;
  logic        col_end, line_end, rep_end, fin;
  logic        pix_on;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign s1_free   = !s1_valid_q || out_free;
  assign in_stall_o = !s1_free || seq_active_q;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign seq_emit   = seq_active_q && s1_free;

  assign s    = eff_scale(scale_q);
  assign step = {9'd0, s, 3'd0};
  assign code_off = in_data_i.char_code - CHAR_FIRST;
  assign code_ok  = (in_data_i.char_code >= CHAR_FIRST) && (in_data_i.char_code <= CHAR_LAST)
                    && (32'(code_off) < GLYPH_COUNT);

  assign put_glyph = in_accept && (in_data_i.func == FUNC_PUT_CHAR)
                     && (in_data_i.char_code != CHAR_NEWLINE) && code_ok;
  assign pix_emit  = in_accept && (in_data_i.func == FUNC_NEXT_PIXEL) && drawing_q;

  assign font_we    = in_accept && (in_data_i.func == FUNC_LOAD_ROW) && code_ok;
  assign font_waddr = FONT_AW'({code_off[6:0], in_data_i.row_index});
  assign font_re    = pix_emit;
  assign font_raddr = FONT_AW'({glyph_q, src_row_q});

  assign col_end  = ({1'b0, col_rep_q} + 5'd1) >= {1'b0, s};
  assign line_end = col_end && (src_col_q == 3'd7);
  assign rep_end  = line_end && (({1'b0, row_rep_q} + 5'd1) >= {1'b0, s});
  assign fin      = rep_end && (src_row_q == 3'd7);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q    <= FG_RESET;
      bg_q    <= BG_RESET;
      scale_q <= SCALE_RESET;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_FG_COLOUR:  fg_q    <= cfg_wdata_i;
        REG_BG_COLOUR:  bg_q    <= cfg_wdata_i;
        REG_TEXT_SCALE: scale_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Cursor and glyph walk
  always_comb begin
    cursor_x_d = cursor_x_q;
    cursor_y_d = cursor_y_q;
    line_x_d   = line_x_q;
    drawing_d  = drawing_q;
    glyph_d    = glyph_q;
    src_row_d  = src_row_q;
    row_rep_d  = row_rep_q;
    src_col_d  = src_col_q;
    col_rep_d  = col_rep_q;
    if (in_accept) begin
      case (in_data_i.func)
        FUNC_SET_CURSOR: begin
          cursor_x_d = in_data_i.start_x;
          line_x_d   = in_data_i.start_x;
          cursor_y_d = in_data_i.start_y;
        end
        FUNC_PUT_CHAR: begin
          if (in_data_i.char_code == CHAR_NEWLINE) begin
            cursor_y_d = cursor_y_q + step;
            cursor_x_d = line_x_q;
          end else begin
            cursor_x_d = cursor_x_q + step;
            if (code_ok) begin
              drawing_d = 1'b1;
              glyph_d   = code_off[6:0];
              src_row_d = 3'd0;
              row_rep_d = 4'd0;
              src_col_d = 3'd0;
              col_rep_d = 4'd0;
            end
          end
        end
        FUNC_NEXT_PIXEL: begin
          if (drawing_q) begin
            if (fin) begin
              drawing_d = 1'b0;
              src_row_d = 3'd0;
              row_rep_d = 4'd0;
              src_col_d = 3'd0;
              col_rep_d = 4'd0;
            end else if (!col_end) begin
              col_rep_d = col_rep_q + 4'd1;
            end else if (!line_end) begin
              col_rep_d = 4'd0;
              src_col_d = src_col_q + 3'd1;
            end else if (!rep_end) begin
              col_rep_d = 4'd0;
              src_col_d = 3'd0;
              row_rep_d = row_rep_q + 4'd1;
            end else begin
              col_rep_d = 4'd0;
              src_col_d = 3'd0;
              row_rep_d = 4'd0;
              src_row_d = src_row_q + 3'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= '0;
      cursor_y_q <= '0;
      line_x_q   <= '0;
      drawing_q  <= 1'b0;
      glyph_q    <= '0;
      src_row_q  <= '0;
      row_rep_q  <= '0;
      src_col_q  <= '0;
      col_rep_q  <= '0;
    end else begin
      cursor_x_q <= cursor_x_d;
      cursor_y_q <= cursor_y_d;
      line_x_q   <= line_x_d;
      drawing_q  <= drawing_d;
      glyph_q    <= glyph_d;
      src_row_q  <= src_row_d;
      row_rep_q  <= row_rep_d;
      src_col_q  <= src_col_d;
      col_rep_q  <= col_rep_d;
    end
  end

  // Window coordinates, captured when a glyph starts
  always_ff @(posedge clk_i) begin
    if (put_glyph) begin
      win_x0_q <= cursor_x_q;
      win_x1_q <= cursor_x_q + step - 16'd1;
      win_y0_q <= cursor_y_q;
      win_y1_q <= cursor_y_q + step - 16'd1;
    end
  end

  // Window setup sequencer
  always_comb begin
    seq_active_d = seq_active_q;
    seq_idx_d    = seq_idx_q;
    if (put_glyph) begin
      seq_active_d = 1'b1;
      seq_idx_d    = '0;
    end else if (seq_emit) begin
      if (seq_idx_q == SEQ_W'(SEQ_LEN - 1)) begin
        seq_active_d = 1'b0;
      end
      seq_idx_d = seq_idx_q + SEQ_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_active_q <= 1'b0;
      seq_idx_q    <= '0;
    end else begin
      seq_active_q <= seq_active_d;
      seq_idx_q    <= seq_idx_d;
    end
  end

  // Font memory
  always_ff @(posedge clk_i) begin
    if (font_we) begin
      font_mem[font_waddr] <= in_data_i.row_bits;
    end
    if (font_re) begin
      font_rdata_q <= font_mem[font_raddr];
    end
  end

  // Request stage
  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_d       = s1_q;
    if (seq_emit) begin
      s1_valid_d = 1'b1;
      s1_d       = seq_entry(seq_idx_q, win_x0_q, win_x1_q, win_y0_q, win_y1_q);
    end else if (pix_emit) begin
      s1_valid_d = 1'b1;
      s1_d.kind  = KIND_PIXEL;
      s1_d.value = 16'd0;
      s1_d.last  = fin;
      s1_d.col   = src_col_q;
    end else if (s1_valid_q && out_free) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  // Output register: pick the glyph bit and colour for pixels
  assign pix_on = font_rdata_q[3'd7 - s1_q.col];

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_free) begin
      out_valid_d = s1_valid_q;
      if (s1_valid_q) begin
        out_d.out_kind = s1_q.kind;
        out_d.last     = s1_q.last;
        if (s1_q.kind == KIND_PIXEL) begin
          out_d.out_value = to_565(pix_on ? fg_q : bg_q);
        end else begin
          out_d.out_value = s1_q.value;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
